// ===== src/char_lcd_nibble_expander_sequencer_defines.svh =====
// ----------------------------------------------------------------------------
// Character LCD expander sequencer: assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_EXPANDER_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_EXPANDER_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LCDNX_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LCDNX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/lcdnx_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdnx_pkg
// Types and constants shared by the character LCD expander sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdnx_pkg;

    // Cursor and geometry
    localparam int CUR_W             = 6;
    localparam int CMP_W             = 7;
    localparam int LINE_LENGTH_DEF   = 16;
    localparam int SCREEN_CELLS_DEF  = 32;

    // Display operation codes
    localparam logic [2:0] OP_CMD    = 3'd0;
    localparam logic [2:0] OP_PRINT  = 3'd1;
    localparam logic [2:0] OP_CURSOR = 3'd2;
    localparam logic [2:0] OP_HOME   = 3'd3;
    localparam logic [2:0] OP_INIT   = 3'd4;

    // LCD command bytes
    localparam logic [7:0] CMD_LINE2_ADDR = 8'hC0;
    localparam logic [7:0] CMD_HOME       = 8'h02;

    // Nibble index where a two-byte, a single-byte and a lone-nibble job start
    localparam logic [1:0] NIB_FIRST  = 2'd0;
    localparam logic [1:0] NIB_BYTE_B = 2'd2;
    localparam logic [1:0] NIB_LAST   = 2'd3;

    // Three transfers per nibble
    typedef enum logic [1:0] {
        PH_SETUP  = 2'd0,
        PH_STROBE = 2'd1,
        PH_HOLD   = 2'd2
    } phase_t;

    // Decoded job: up to two LCD bytes, walked from start_nib to nibble 3
    typedef struct packed {
        logic [7:0] byte_a;
        logic       rs_a;
        logic [7:0] byte_b;
        logic       rs_b;
        logic [1:0] start_nib;
    } job_t;

endpackage

`default_nettype wire

// ===== src/lcdnx_decode.sv =====
// ----------------------------------------------------------------------------
// lcdnx_decode
// Decodes an operation into an LCD byte job and tracks the cursor state.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdnx_decode
    import lcdnx_pkg::*;
#(
    parameter int LINE_LENGTH  = LINE_LENGTH_DEF,
    parameter int SCREEN_CELLS = SCREEN_CELLS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [2:0] op,
    input  wire logic [7:0] data_byte,
    input  wire logic       row,
    input  wire logic [3:0] col,
    output job_t            job,
    output logic            job_load
);

    logic [CUR_W-1:0] cursor_reg;
    logic [CUR_W-1:0] cursor_next;
    logic             wrap_set_reg;
    logic             wrap_set_next;
    logic [CUR_W-1:0] set_pos;
    logic             off_screen;
    logic             need_wrap;
    logic             has_results;

    assign set_pos    = CUR_W'(col) + (row ? CUR_W'(LINE_LENGTH) : CUR_W'(0));
    assign off_screen = {1'b0, cursor_reg} >= CMP_W'(SCREEN_CELLS);
    assign need_wrap  = (cursor_reg == CUR_W'(LINE_LENGTH)) && !wrap_set_reg;

    // Build the job and the next cursor state
    always_comb
    begin
        job.byte_a    = CMD_LINE2_ADDR;
        job.rs_a      = 1'b0;
        job.byte_b    = data_byte;
        job.rs_b      = 1'b0;
        job.start_nib = NIB_BYTE_B;
        has_results   = 1'b1;
        cursor_next   = cursor_reg;
        wrap_set_next = wrap_set_reg;
        case (op)
            OP_CMD:
            begin
                job.byte_b = data_byte;
            end
            OP_PRINT:
            begin
                job.rs_b = 1'b1;
                if (off_screen)
                begin
                    has_results = 1'b0;
                end
                else
                begin
                    if (need_wrap)
                    begin
                        job.start_nib = NIB_FIRST;
                    end
                    cursor_next   = cursor_reg + CUR_W'(1);
                    wrap_set_next = 1'b0;
                end
            end
            OP_CURSOR:
            begin
                job.byte_b    = {1'b1, row, 2'b00, col};
                cursor_next   = set_pos;
                wrap_set_next = (set_pos == CUR_W'(LINE_LENGTH));
            end
            OP_HOME:
            begin
                job.byte_b    = CMD_HOME;
                cursor_next   = '0;
                wrap_set_next = 1'b0;
            end
            OP_INIT:
            begin
                // Lone nibble goes out as the low half of byte B
                job.byte_b    = {4'h0, data_byte[7:4]};
                job.start_nib = NIB_LAST;
            end
            default:
            begin
                has_results = 1'b0;
            end
        endcase
    end

    assign job_load = accept && has_results;

    // Hold cursor state, update it on each accepted operation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg   <= '0;
            wrap_set_reg <= 1'b0;
        end
        else if (accept)
        begin
            cursor_reg   <= cursor_next;
            wrap_set_reg <= wrap_set_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/lcdnx_emit.sv =====
// ----------------------------------------------------------------------------
// lcdnx_emit
// Walks a job nibble by nibble and drives the registered expander byte stream.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdnx_emit
    import lcdnx_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire job_t       job,
    input  wire logic       job_load,
    input  wire logic       backlight,
    output logic            take_ok,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] expander_byte
    output logic            m_tlast
);

    job_t       job_reg;
    logic       job_valid_reg;
    logic       job_valid_next;
    logic [1:0] nib_reg;
    logic [1:0] nib_next;
    phase_t     phase_reg;
    phase_t     phase_next;
    logic       m_valid_reg;
    logic [7:0] m_data_reg;
    logic       m_last_reg;

    logic       out_free;
    logic       advance;
    logic       job_last;
    logic [3:0] nibble;
    logic       rs;
    logic [7:0] byte_out;

    assign out_free = !m_valid_reg || m_tready;
    assign advance  = job_valid_reg && out_free;
    assign job_last = (nib_reg == NIB_LAST) && (phase_reg == PH_HOLD);
    assign take_ok  = !job_valid_reg || (advance && job_last);

    // Select the current nibble and its register-select bit
    always_comb
    begin
        case (nib_reg)
            2'd0:    nibble = job_reg.byte_a[7:4];
            2'd1:    nibble = job_reg.byte_a[3:0];
            2'd2:    nibble = job_reg.byte_b[7:4];
            default: nibble = job_reg.byte_b[3:0];
        endcase
        rs       = nib_reg[1] ? job_reg.rs_b : job_reg.rs_a;
        byte_out = {nibble, backlight, (phase_reg == PH_STROBE), 1'b0, rs};
    end

    // Step through setup, strobe and hold for each nibble
    always_comb
    begin
        job_valid_next = job_valid_reg;
        nib_next       = nib_reg;
        phase_next     = phase_reg;
        if (advance)
        begin
            case (phase_reg)
                PH_SETUP:  phase_next = PH_STROBE;
                PH_STROBE: phase_next = PH_HOLD;
                default:
                begin
                    phase_next = PH_SETUP;
                    nib_next   = nib_reg + 2'd1;
                end
            endcase
            if (job_last)
            begin
                job_valid_next = 1'b0;
            end
        end
        if (job_load)
        begin
            job_valid_next = 1'b1;
            nib_next       = job.start_nib;
            phase_next     = PH_SETUP;
        end
    end

    // Hold sequencer control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            nib_reg       <= NIB_FIRST;
            phase_reg     <= PH_SETUP;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            nib_reg       <= nib_next;
            phase_reg     <= phase_next;
            if (out_free)
            begin
                m_valid_reg <= advance;
            end
        end
    end

    // Load job and output payload
    always_ff @(posedge clk)
    begin
        if (job_load)
        begin
            job_reg <= job;
        end
        if (advance)
        begin
            m_data_reg <= byte_out;
            m_last_reg <= job_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

// ===== src/char_lcd_nibble_expander_sequencer.sv =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_expander_sequencer
// Display operations in, HD44780 4-bit expander byte stream out.
// ----------------------------------------------------------------------------
// Each accepted operation produces 3 (init nibble), 6 (command, character, set
// cursor, home) or 12 (character with the second-line address first) expander
// bytes, one per cycle while the output is taken; tlast marks the final byte.
// The rate is set by the single nibble sequencer feeding the output register:
// an item occupies it until its final byte has been issued, and the next item
// is taken in the cycle the final byte moves into the output register.
// Dropped characters and undefined operations are accepted and emit nothing.
// The backlight register may be written only while the stream is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_nibble_expander_sequencer
    import lcdnx_pkg::*;
#(
    parameter int LINE_LENGTH  = LINE_LENGTH_DEF,
    parameter int SCREEN_CELLS = SCREEN_CELLS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,    // [0] backlight_on
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,     // [7:0] data_byte, [8] row, [12:9] col,
                                          // [15:13] zero
    input  wire logic [2:0]  s_tuser,     // [2:0] op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,     // [7:0] expander_byte
    output logic             m_tlast
);

    logic backlight_reg;
    logic accept;
    job_t job;
    logic job_load;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    // Hold backlight setting
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            backlight_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            backlight_reg <= cfg_data;
        end
    end

    lcdnx_decode #(
        .LINE_LENGTH  (LINE_LENGTH),
        .SCREEN_CELLS (SCREEN_CELLS)
    ) u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .op        (s_tuser),
        .data_byte (s_tdata[7:0]),
        .row       (s_tdata[8]),
        .col       (s_tdata[12:9]),
        .job       (job),
        .job_load  (job_load)
    );

    lcdnx_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job),
        .job_load  (job_load),
        .backlight (backlight_reg),
        .take_ok   (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

// ===== src/lcdnx_sva.sv =====
// ----------------------------------------------------------------------------
// lcdnx_sva
// Port-level checks on the expander byte stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "char_lcd_nibble_expander_sequencer_defines.svh"

module lcdnx_sva
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tready,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [7:0]  m_tdata,
    input  wire logic        m_tlast
);

    // Stalled output transfer holds its payload
    `LCDNX_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled output changed")

    // A strobe byte is never the final byte of an operation
    `LCDNX_ASSERT_IMPL(a_strobe_not_last, clk, rst_n, m_tvalid && m_tdata[2], !m_tlast, "enable high on last byte")

    // Read/write bit stays low: writes only
    `LCDNX_ASSERT_IMPL(a_rw_low, clk, rst_n, m_tvalid, !m_tdata[1], "rw bit set")

    // Input back-pressure only while bytes are in flight
    `LCDNX_ASSERT_NEXT(a_busy_emits, clk, rst_n, !s_tready, m_tvalid, "input stalled with no output")

endmodule

bind char_lcd_nibble_expander_sequencer lcdnx_sva u_lcdnx_sva (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== bench/lcd_stream_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lcd_stream_checker
// Watches the operation, backlight and expander channels of the character LCD
// sequencer, builds the expected expander byte stream for every accepted
// operation and compares each byte and its tlast in order.
// ----------------------------------------------------------------------------

module lcd_stream_checker
    import lcdnx_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic        cfg_data,    // [0] backlight_on
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [15:0] s_tdata,     // [7:0] data_byte, [8] row, [12:9] col,
                                          // [15:13] zero
    input  wire logic [2:0]  s_tuser,     // [2:0] op
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [7:0]  m_tdata,     // [7:0] expander_byte
    input  wire logic        m_tlast,
    output int               error_count,
    output int               pending_bytes
);

    // Expander byte layout and LCD address command bits
    localparam logic [7:0] BIT_RS      = 8'h01;
    localparam logic [7:0] BIT_EN      = 8'h04;
    localparam logic [7:0] BIT_BL      = 8'h08;
    localparam logic [7:0] NIB_HIGH    = 8'hF0;
    localparam logic [7:0] DDRAM_SET   = 8'h80;
    localparam logic [7:0] DDRAM_LINE2 = 8'h40;
    localparam logic [7:0] MODE_CMD    = 8'h00;

    typedef struct packed {
        logic [7:0] xbyte;
        logic       is_last;
    } lcd_beat_t;

    lcd_beat_t        beat_q[$];
    logic [7:0]       seq_bytes[$];
    logic             backlight;
    logic [CUR_W-1:0] cursor_pos;
    logic             wrap_set;

    // Append one nibble as setup, strobe and hold bytes
    function automatic void add_nibble(input logic [7:0] bits);
        logic [7:0] bl;
        bl = backlight ? BIT_BL : 8'h00;
        seq_bytes.push_back(bits | bl);
        seq_bytes.push_back(bits | BIT_EN | bl);
        seq_bytes.push_back((bits & ~BIT_EN) | bl);
    endfunction

    // Append a full LCD byte, high nibble first
    function automatic void add_lcd_byte(input logic [7:0] data, input logic [7:0] mode);
        add_nibble((data & NIB_HIGH) | mode);
        add_nibble({data[3:0], 4'h0} | mode);
    endfunction

    // Advance the display state for one operation and queue its bytes
    function automatic void predict_op(input logic [2:0] kind, input logic [15:0] word);
        logic [2:0] op;
        logic [7:0] code;
        logic       row;
        logic [3:0] col;
        int         k;
        op   = kind;
        code = word[7:0];
        row  = word[8];
        col  = word[12:9];
        seq_bytes.delete();
        case (op)
            OP_CMD: add_lcd_byte(code, MODE_CMD);
            OP_PRINT:
            begin
                if (int'(cursor_pos) < SCREEN_CELLS_DEF)
                begin
                    if (int'(cursor_pos) == LINE_LENGTH_DEF && !wrap_set)
                        add_lcd_byte(CMD_LINE2_ADDR, MODE_CMD);
                    add_lcd_byte(code, BIT_RS);
                    cursor_pos = cursor_pos + 1'b1;
                    wrap_set   = 1'b0;
                end
            end
            OP_CURSOR:
            begin
                add_lcd_byte(DDRAM_SET | {4'h0, col} | (row ? DDRAM_LINE2 : 8'h00), MODE_CMD);
                cursor_pos = CUR_W'(int'(col) + (row ? LINE_LENGTH_DEF : 0));
                wrap_set   = (int'(cursor_pos) == LINE_LENGTH_DEF);
            end
            OP_HOME:
            begin
                add_lcd_byte(CMD_HOME, MODE_CMD);
                cursor_pos = '0;
                wrap_set   = 1'b0;
            end
            OP_INIT: add_nibble(code & NIB_HIGH);
            default: ;
        endcase
        for (k = 0; k < seq_bytes.size(); k++)
            beat_q.push_back('{xbyte: seq_bytes[k], is_last: (k == seq_bytes.size() - 1)});
    endfunction

    // Compare outgoing transfers first, then track config and new operations
    always @(posedge clk)
    begin : check_proc
        lcd_beat_t want;
        if (!rst_n)
        begin
            beat_q.delete();
            backlight     = 1'b0;
            cursor_pos    = '0;
            wrap_set      = 1'b0;
            error_count   = 0;
            pending_bytes <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (beat_q.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected expander transfer, expected none, got %02h last %b",
                             $time, m_tdata, m_tlast);
                end
                else
                begin
                    want = beat_q.pop_front();
                    if (m_tdata !== want.xbyte)
                    begin
                        error_count++;
                        $display("%0t: expander byte mismatch, expected %02h, got %02h",
                                 $time, want.xbyte, m_tdata);
                    end
                    if (m_tlast !== want.is_last)
                    begin
                        error_count++;
                        $display("%0t: tlast mismatch, expected %b, got %b",
                                 $time, want.is_last, m_tlast);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                backlight = cfg_data;
            if (s_tvalid && s_tready)
                predict_op(s_tuser, s_tdata);
            pending_bytes <= beat_q.size();
        end
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives display operations and backlight writes into the character LCD
// sequencer with random gaps and output stalls, including a long output
// hold-off that backs up the input; the checker predicts and compares.
// ----------------------------------------------------------------------------

module tb_top;
    import lcdnx_pkg::*;

    // Operation codes the block ignores
    localparam logic [2:0] OP_UNDEF_LO = 3'd5;
    localparam logic [2:0] OP_UNDEF_HI = 3'd7;
    localparam int         HOLD_CYCLES = 300;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_data  = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [15:0] s_tdata   = '0;
    logic [2:0]  s_tuser   = '0;
    logic        m_tready  = 1'b0;
    logic        cfg_ready;
    logic        s_tready;
    logic        m_tvalid;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    logic        no_idle   = 1'b0;
    logic        hold_req  = 1'b0;
    logic        hold_off  = 1'b0;
    int          rx_stall  = 0;
    int          error_count;
    int          pending_bytes;

    always #10 clk = ~clk;

    char_lcd_nibble_expander_sequencer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    lcd_stream_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .error_count   (error_count),
        .pending_bytes (pending_bytes)
    );

    // Output side: stall a random number of cycles after each transfer
    always @(posedge clk or negedge rst_n)
    begin : rx_proc
        int n;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_stall <= 0;
        end
        else if (hold_off)
            m_tready <= 1'b0;
        else if (rx_stall != 0)
        begin
            m_tready <= 1'b0;
            rx_stall <= rx_stall - 1;
        end
        else if (m_tready && m_tvalid)
        begin
            n = no_idle ? 0 : $urandom_range(0, 11);
            if (n == 0)
                m_tready <= 1'b1;
            else
            begin
                m_tready <= 1'b0;
                rx_stall <= n - 1;
            end
        end
        else
            m_tready <= 1'b1;
    end

    // Long output hold-off, counted here so the sender keeps pushing
    initial
    begin
        wait (hold_req);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("[char_lcd_nibble_expander_sequencer] ERROR");
        $finish;
    end

    // Offer one operation after a random gap and wait for its transfer
    task automatic send_op(input logic [2:0] op, input logic [7:0] code,
                           input logic row, input logic [3:0] col);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, col, row, code};
        s_tuser  <= op;
        do @(posedge clk); while (!s_tready);
    endtask

    // Random operation, biased toward printing so the cursor runs off the screen
    task automatic send_random(output bit counted);
        int         r;
        logic [2:0] op;
        r = $urandom_range(0, 99);
        if (r < 40)      op = OP_PRINT;
        else if (r < 55) op = OP_CURSOR;
        else if (r < 62) op = OP_HOME;
        else if (r < 77) op = OP_CMD;
        else if (r < 90) op = OP_INIT;
        else             op = 3'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
        counted = (op <= OP_INIT);
        send_op(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                4'($urandom_range(0, 15)));
    endtask

    task automatic run_random(input int target);
        int n;
        bit counted;
        n = 0;
        while (n < target)
        begin
            send_random(counted);
            if (counted)
                n++;
        end
    endtask

    // Drop valid and wait until every expected byte has left
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_bytes != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_backlight(input logic value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, each operation, line wrap and screen end
        write_backlight(1'b0);
        send_op(OP_CMD,      8'h00, 1'b0, 4'h0);
        send_op(OP_CMD,      8'hFF, 1'b1, 4'hF);
        send_op(OP_INIT,     8'hF0, 1'b0, 4'h0);
        send_op(OP_INIT,     8'h0F, 1'b1, 4'hF);
        send_op(OP_HOME,     8'h00, 1'b0, 4'h0);
        send_op(OP_CURSOR,   8'h00, 1'b0, 4'h0);
        send_op(OP_CURSOR,   8'hFF, 1'b1, 4'hF);
        send_op(OP_CURSOR,   8'h00, 1'b0, 4'hF);
        send_op(OP_PRINT,    8'h41, 1'b0, 4'h0);
        send_op(OP_PRINT,    8'h42, 1'b0, 4'h0);   // second-line address first
        send_op(OP_CURSOR,   8'h00, 1'b1, 4'h0);   // cursor set exactly at the wrap
        send_op(OP_PRINT,    8'h43, 1'b0, 4'h0);
        send_op(OP_CURSOR,   8'h00, 1'b1, 4'hE);
        send_op(OP_PRINT,    8'hFF, 1'b1, 4'hF);
        send_op(OP_PRINT,    8'h00, 1'b0, 4'h0);
        send_op(OP_PRINT,    8'h55, 1'b0, 4'h0);   // past the screen, dropped
        send_op(OP_CMD,      8'hA5, 1'b0, 4'h0);
        send_op(OP_UNDEF_LO, 8'hFF, 1'b1, 4'hF);
        send_op(OP_UNDEF_HI, 8'h00, 1'b0, 4'h0);
        send_op(OP_HOME,     8'hFF, 1'b1, 4'hF);
        send_op(OP_PRINT,    8'h7E, 1'b1, 4'hA);

        // Random with backlight on and random idling
        write_backlight(1'b1);
        run_random(45);

        // Back-to-back bursts, then idling again, backlight off
        write_backlight(1'b0);
        no_idle <= 1'b1;
        run_random(15);
        no_idle <= 1'b0;
        run_random(25);

        // Hold the output off while the input keeps offering items
        write_backlight(1'b1);
        no_idle  <= 1'b1;
        hold_req <= 1'b1;
        run_random(35);
        no_idle  <= 1'b0;

        drain();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("[char_lcd_nibble_expander_sequencer] OK");
        else
            $display("[char_lcd_nibble_expander_sequencer] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/lcdnx_pkg.sv
src/lcdnx_decode.sv
src/lcdnx_emit.sv
src/char_lcd_nibble_expander_sequencer.sv
src/lcdnx_sva.sv
bench/lcd_stream_checker.sv
bench/tb_top.sv
